/* src/vlrt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vlrt_pkg
// Shared types and constants for the value list with remove and totals.
// ----------------------------------------------------------------------------
package vlrt_pkg;

   localparam int VALUE_W = 16;
   localparam int ENTRY_W = 15;
   localparam int COUNT_W = 6;
   localparam int TOTAL_W = 20;

   localparam logic KIND_ENTRY  = 1'b0;
   localparam logic KIND_TOTALS = 1'b1;

   typedef enum logic [1:0] {
      OP_APPEND,
      OP_REMOVE,
      OP_REPORT
   } op_type;

   // decoded command: operation and the value or magnitude it carries
   typedef struct packed {
      op_type             op;
      logic [VALUE_W-1:0] mag;
   } cmd_type;

   typedef struct packed {
      logic               kind;
      logic [ENTRY_W-1:0] entry;
      logic [COUNT_W-1:0] count;
      logic [TOTAL_W-1:0] total;
      logic               overflowed;
      logic               last;
   } rsp_type;

endpackage : vlrt_pkg
`default_nettype wire

/* src/vlrt_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vlrt_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module vlrt_mem #(
   parameter int  DEPTH  = 32,
   parameter int  DATA_W = 15,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [DATA_W-1:0] wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule : vlrt_mem
`default_nettype wire

/* src/vlrt_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vlrt_ctrl
// Sequencer: appends, compacting remove walk and report walk over the store.
// ----------------------------------------------------------------------------
module vlrt_ctrl #(
   parameter int  CAPACITY = 32,
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire vlrt_pkg::cmd_type                 cmd,
   output logic                                   busy,
   output logic                                   mem_we,
   output logic [ADDR_W-1:0]                      mem_waddr,
   output logic [vlrt_pkg::ENTRY_W-1:0]           mem_wdata,
   output logic                                   mem_re,
   output logic [ADDR_W-1:0]                      mem_raddr,
   input  wire logic [vlrt_pkg::ENTRY_W-1:0]      mem_rdata,
   output logic                                   rsp_valid,
   output vlrt_pkg::rsp_type                      rsp
);
   import vlrt_pkg::*;

   localparam int FILL_W = $clog2(CAPACITY + 1);
   localparam logic [FILL_W-1:0] FILL_ONE = FILL_W'(1);
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(CAPACITY);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REMOVE,
      ST_REPORT
   } state_type;

   state_type          state_ff;
   logic [FILL_W-1:0]  fill_ff;
   logic               flag_ff;
   logic [FILL_W-1:0]  idx_ff;
   logic [FILL_W-1:0]  keep_ff;
   logic               pend_ff;
   logic [VALUE_W-1:0] mag_ff;
   logic [TOTAL_W-1:0] sum_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic accept;
   logic full;
   logic rd_go;
   logic keep_hit;
   logic walk_done;
   logic append_we;

   always_comb begin
      accept    = start && (state_ff == ST_IDLE);
      full      = (fill_ff == FILL_MAX);
      rd_go     = (state_ff != ST_IDLE) && (idx_ff != fill_ff);
      walk_done = !rd_go && !pend_ff;
      keep_hit  = pend_ff && (state_ff == ST_REMOVE)
                  && ({1'b0, mem_rdata} != mag_ff);
      append_we = accept && (cmd.op == OP_APPEND) && !full;
      mem_re    = rd_go;
      mem_raddr = idx_ff[ADDR_W-1:0];
      mem_we    = append_we || keep_hit;
      mem_waddr = keep_hit ? keep_ff[ADDR_W-1:0] : fill_ff[ADDR_W-1:0];
      mem_wdata = keep_hit ? mem_rdata : cmd.mag[ENTRY_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         flag_ff      <= 1'b0;
         idx_ff       <= '0;
         keep_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // strobe for every stored entry and for the closing totals item
         rsp_valid_ff <= (state_ff == ST_REPORT) && (pend_ff || walk_done);
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  idx_ff  <= '0;
                  keep_ff <= '0;
                  pend_ff <= 1'b0;
                  unique case (cmd.op)
                     OP_APPEND: begin
                        if (full) begin
                           flag_ff <= 1'b1;
                        end else begin
                           fill_ff <= fill_ff + FILL_ONE;
                        end
                     end
                     OP_REMOVE: begin
                        mag_ff   <= cmd.mag;
                        state_ff <= ST_REMOVE;
                     end
                     OP_REPORT: begin
                        sum_ff   <= '0;
                        state_ff <= ST_REPORT;
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            ST_REMOVE: begin
               if (rd_go) begin
                  idx_ff <= idx_ff + FILL_ONE;
               end
               pend_ff <= rd_go;
               if (keep_hit) begin
                  keep_ff <= keep_ff + FILL_ONE;
               end
               if (walk_done) begin
                  fill_ff  <= keep_ff;
                  state_ff <= ST_IDLE;
               end
            end
            ST_REPORT: begin
               if (rd_go) begin
                  idx_ff <= idx_ff + FILL_ONE;
               end
               pend_ff <= rd_go;
               if (pend_ff) begin
                  // emit one stored entry and fold it into the running sum
                  rsp_ff.kind       <= KIND_ENTRY;
                  rsp_ff.entry      <= mem_rdata;
                  rsp_ff.count      <= '0;
                  rsp_ff.total      <= '0;
                  rsp_ff.overflowed <= 1'b0;
                  rsp_ff.last       <= 1'b0;
                  sum_ff            <= sum_ff + TOTAL_W'(mem_rdata);
               end
               if (walk_done) begin
                  rsp_ff.kind       <= KIND_TOTALS;
                  rsp_ff.entry      <= '0;
                  rsp_ff.count      <= COUNT_W'(fill_ff);
                  rsp_ff.total      <= sum_ff;
                  rsp_ff.overflowed <= flag_ff;
                  rsp_ff.last       <= 1'b1;
                  fill_ff           <= '0;
                  flag_ff           <= 1'b0;
                  state_ff          <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule : vlrt_ctrl
`default_nettype wire

/* src/value_list_remove_and_total_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// value_list_remove_and_total_top
// Ordered list of positive values with append, remove-all-by-value and a
// report that lists every entry followed by a totals item, then empties the list.
// ----------------------------------------------------------------------------
//  Channel   Ports                          Handshake
//  request   req_value                      start & !busy accepts the item
//  response  rsp_kind .. rsp_last           rsp_valid strobe, one cycle each
//
//  Append: taken in the accept cycle, busy stays low.
//  Remove and report: busy while the store is walked, one read per cycle
//  through its single read port, with registered read data.
//  Report results follow one per cycle, the totals item last.
//  Synchronous reset empties the list and clears the overflow flag.
//  The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module value_list_remove_and_total_top #(
   parameter int CAPACITY = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic signed [vlrt_pkg::VALUE_W-1:0] req_value,
   output logic                                   rsp_valid,
   output logic                                   rsp_kind,
   output logic [vlrt_pkg::ENTRY_W-1:0]           rsp_entry,
   output logic [vlrt_pkg::COUNT_W-1:0]           rsp_count,
   output logic [vlrt_pkg::TOTAL_W-1:0]           rsp_total,
   output logic                                   rsp_overflowed,
   output logic                                   rsp_last
);
   import vlrt_pkg::*;

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic [VALUE_W-1:0] raw;
   cmd_type            cmd;
   rsp_type            rsp;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;
   logic               mem_re;
   logic [ADDR_W-1:0]  mem_raddr;
   logic [ENTRY_W-1:0] mem_rdata;

   // decode the signed value into an operation and a magnitude
   always_comb begin
      raw = req_value;
      if (raw == '0) begin
         cmd.op  = OP_REPORT;
         cmd.mag = '0;
      end else if (!raw[VALUE_W-1]) begin
         cmd.op  = OP_APPEND;
         cmd.mag = raw;
      end else begin
         cmd.op  = OP_REMOVE;
         cmd.mag = ~raw + VALUE_W'(1);
      end
   end

   vlrt_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .cmd       (cmd),
      .busy      (busy),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   vlrt_mem #(
      .DEPTH  (CAPACITY),
      .DATA_W (ENTRY_W)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign rsp_kind       = rsp.kind;
   assign rsp_entry      = rsp.entry;
   assign rsp_count      = rsp.count;
   assign rsp_total      = rsp.total;
   assign rsp_overflowed = rsp.overflowed;
   assign rsp_last       = rsp.last;

   // a report or remove raises busy in the cycle after it is accepted
   a_walk_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (cmd.op == OP_REPORT || cmd.op == OP_REMOVE)) |=> busy)
      else $error("walk command did not raise busy");

   // entry items carry no totals and never close a report
   a_entry_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_ENTRY) |->
      (rsp_count == '0 && rsp_total == '0 && !rsp_last && !rsp_overflowed))
      else $error("entry item carries totals fields");

   // entries come out only from a report walk in progress
   a_entry_in_walk: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_ENTRY) |-> $past(busy))
      else $error("entry item outside a report walk");

   // the store is never read and written by an idle append in the same cycle
   a_no_append_in_walk: assert property (@(posedge clock) disable iff (reset)
      (mem_re && mem_we) |-> busy)
      else $error("store access overlap outside a walk");

endmodule : value_list_remove_and_total_top
`default_nettype wire

/* verif/value_list_remove_and_total_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_list_remove_and_total_top_tb
// Self-checking bench for the ordered value list. Appends, remove-all-by-value
// commands and reports are driven through the start/busy port. Every accepted
// command updates a shadow list, which queues the entry and totals items that
// a report must produce. Each rsp_valid strobe is checked field by field in
// order. The run mixes well-formed fill/remove/report sequences, overflow
// fills, raw noise values and unfinished sequences, with varying sender gaps.
// ----------------------------------------------------------------------------
module value_list_remove_and_total_top_tb;
   import vlrt_pkg::*;

   localparam int CAPACITY       = 32;
   localparam int DIRECTED_LEN   = 13;
   localparam int RANDOM_PER_PHASE = 152;
   localparam int WATCHDOG_LIMIT = 4000;

   class list_scoreboard;
      logic [ENTRY_W-1:0] stored [CAPACITY];
      int unsigned        fill;
      bit                 dropped;
      rsp_type            expected_q [$];
      int                 errors;

      function new();
         fill    = 0;
         dropped = 0;
         errors  = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function op_type decode(logic [VALUE_W-1:0] value);
         if (value == '0)
            return OP_REPORT;
         else if (value[VALUE_W-1])
            return OP_REMOVE;
         else
            return OP_APPEND;
      endfunction

      // update the shadow list and queue the items a report produces
      function void note_item(logic [VALUE_W-1:0] value);
         rsp_type            item;
         int unsigned        keep;
         int unsigned        mag;
         logic [TOTAL_W-1:0] sum;
         case (decode(value))
            OP_APPEND: begin
               if (fill < CAPACITY) begin
                  stored[fill] = value[ENTRY_W-1:0];
                  fill++;
               end else begin
                  dropped = 1'b1;
               end
            end
            OP_REMOVE: begin
               // magnitude of the most negative value is out of entry range
               mag  = 32'h10000 - value;
               keep = 0;
               for (int i = 0; i < fill; i++) begin
                  if (stored[i] != mag) begin
                     stored[keep] = stored[i];
                     keep++;
                  end
               end
               fill = keep;
            end
            default: begin
               sum = '0;
               for (int i = 0; i < fill; i++) begin
                  item            = '0;
                  item.kind       = KIND_ENTRY;
                  item.entry      = stored[i];
                  expected_q.insert(expected_q.size(), item);
                  sum += TOTAL_W'(stored[i]);
               end
               item            = '0;
               item.kind       = KIND_TOTALS;
               item.count      = COUNT_W'(fill);
               item.total      = sum;
               item.overflowed = dropped;
               item.last       = 1'b1;
               expected_q.insert(expected_q.size(), item);
               fill    = 0;
               dropped = 0;
            end
         endcase
      endfunction

      function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (act_v !== exp_v) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type exp_item;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result: expected none, got kind %0d entry %0d",
                     $time, got.kind, got.entry);
            errors++;
            return;
         end
         exp_item = expected_q.pop_front();
         compare_field("kind", exp_item.kind, got.kind);
         compare_field("entry", exp_item.entry, got.entry);
         compare_field("count", exp_item.count, got.count);
         compare_field("total", exp_item.total, got.total);
         compare_field("overflowed", exp_item.overflowed, got.overflowed);
         compare_field("last", exp_item.last, got.last);
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_kind;
   logic [ENTRY_W-1:0]        rsp_entry;
   logic [COUNT_W-1:0]        rsp_count;
   logic [TOTAL_W-1:0]        rsp_total;
   logic                      rsp_overflowed;
   logic                      rsp_last;

   list_scoreboard sb;
   int             items_sent  = 0;
   int             idle_pct    = 0;
   int             idle_cycles = 0;
   bit             overflow_done = 0;
   logic [ENTRY_W-1:0] pool [4];

   value_list_remove_and_total_top #(
      .CAPACITY(CAPACITY)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_kind      (rsp_kind),
      .rsp_entry     (rsp_entry),
      .rsp_count     (rsp_count),
      .rsp_total     (rsp_total),
      .rsp_overflowed(rsp_overflowed),
      .rsp_last      (rsp_last)
   );

   always #1 clock = ~clock;

   // check results before noting a new item: results at this edge are older
   always @(posedge clock) begin
      rsp_type got;
      if (!reset) begin
         got.kind       = rsp_kind;
         got.entry      = rsp_entry;
         got.count      = rsp_count;
         got.total      = rsp_total;
         got.overflowed = rsp_overflowed;
         got.last       = rsp_last;
         if (rsp_valid)
            sb.check_result(got);
         if (start && !busy)
            sb.note_item(req_value);
         if (rsp_valid || (start && !busy))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // hold the item until accepted, then idle for a random gap
   task automatic send_item(input logic [VALUE_W-1:0] value);
      int gap;
      start     <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      items_sent++;
      gap = 0;
      if (idle_pct > 0 && $urandom_range(19) == 0)
         gap = $urandom_range(1, 40);
      while ($urandom_range(99) < idle_pct)
         gap++;
      if (gap > 0) begin
         start     <= 1'b0;
         req_value <= VALUE_W'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
      // removes give no result but keep the block busy
      repeat (CAPACITY + 4) @(posedge clock);
   endtask

   task automatic remove_value(input logic [ENTRY_W-1:0] mag);
      send_item(VALUE_W'(-int'(mag)));
   endtask

   task automatic run_sequence();
      int                 kind;
      int                 n_ops;
      int                 r;
      logic [ENTRY_W-1:0] prev;
      kind = overflow_done ? $urandom_range(9) : 6;
      for (int i = 0; i < 4; i++)
         pool[i] = ENTRY_W'(($urandom_range(1) != 0) ? $urandom_range(1, 32767)
                                                      : $urandom_range(1, 8));
      prev = pool[0];
      if (kind <= 5 || kind == 9) begin
         n_ops = (kind == 9) ? $urandom_range(1, 5) : $urandom_range(1, 14);
         repeat (n_ops) begin
            r = $urandom_range(9);
            if (r < 6) begin
               // repeat the previous append now and then to build adjacent duplicates
               if ($urandom_range(9) >= 3)
                  prev = pool[$urandom_range(3)];
               send_item({1'b0, prev});
            end else if (r < 9) begin
               remove_value(pool[$urandom_range(3)]);
            end else begin
               remove_value(ENTRY_W'($urandom_range(1, 32767)));
            end
         end
         if (kind != 9)
            send_item('0);
      end else if (kind == 6) begin
         overflow_done = 1;
         repeat ($urandom_range(32, 40)) begin
            if ($urandom_range(3) == 0)
               send_item({1'b0, pool[$urandom_range(3)]});
            else
               send_item({1'b0, 15'($urandom_range(1, 32767))});
         end
         if ($urandom_range(1) != 0)
            remove_value(pool[$urandom_range(3)]);
         send_item('0);
      end else begin
         repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(15) == 0)
               send_item(16'h8000);
            else
               send_item(VALUE_W'($urandom));
         end
      end
   endtask

   initial begin
      int pcts [3];
      pcts = '{0, 50, 7};
      sb   = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // report on empty list, extremes, adjacent duplicates, no-match removes
      send_item('0);
      send_item(16'h7FFF);
      send_item(16'h0001);
      send_item(16'h0001);
      send_item(16'h0001);
      send_item(16'h0005);
      remove_value(15'd1);
      send_item(16'h8000);
      remove_value(15'd7);
      send_item('0);
      send_item(16'h7FFF);
      send_item(16'h8001);
      send_item('0);
      drain();

      for (int p = 0; p < 3; p++) begin
         idle_pct = pcts[p];
         while (items_sent < DIRECTED_LEN + (p + 1) * RANDOM_PER_PHASE)
            run_sequence();
         drain();
      end

      if (sb.errors == 0 && sb.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
